// ===== hdl/rfd_pkg.sv =====
// Shared types, constants and helpers of the rangefinder frame deframer.
package rfd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h5A;
    localparam int         FRAME_LEN   = 22;
    localparam int         WIN_AW      = $clog2(FRAME_LEN);
    localparam int         CNT_W       = $clog2(FRAME_LEN + 1);
    localparam int         FIFO_DEPTH  = 4;
    localparam int         FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_ECHO = 1'b1;

    // One request from the front queue: the byte and whether it is a header.
    typedef struct packed {
        logic [7:0] data;
        logic       is_header;
    } rx_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] algorithm_word;
        logic [15:0] raw_distance_a;
        logic [15:0] raw_distance_b;
        logic [15:0] raw_distance_c;
        logic [15:0] distance_a;
        logic [15:0] distance_b;
        logic [15:0] distance_c;
        logic [7:0]  apd_level;
        logic [15:0] supply_word;
        logic [15:0] temperature_raw;
        logic [31:0] echo_word;
    } result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_DROP,
        ST_SYNC
    } eng_state_t;

    function automatic logic known_id(input logic [7:0] id);
        return id inside {8'h01, 8'h02, 8'h10, 8'h11, [8'h40:8'h47], [8'h4B:8'h4E]};
    endfunction

endpackage

// ===== hdl/rfd_byte_fifo.sv =====
// Front part: accepts received bytes, tags headers and queues them for the engine.
module rfd_byte_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    output logic              item_valid,
    output rfd_pkg::rx_item_t item,
    input  logic              item_pop
);
    import rfd_pkg::*;

    rx_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 push_ok;
    logic                 pop_ok;
    rx_item_t             item_in;

    assign full       = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = item_pop && item_valid;

    always_comb
    begin
        item_in.data      = rx_byte;
        item_in.is_header = (rx_byte == HEADER_BYTE);
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== hdl/rfd_frame_engine.sv =====
// Back part: holds the byte window, checks frames, emits results and resyncs.
module rfd_frame_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  rfd_pkg::rx_item_t rx_item,
    output logic              rx_pop,
    output logic              res_valid,
    input  logic              res_pop,
    output rfd_pkg::result_t  result
);
    import rfd_pkg::*;

    eng_state_t         state_reg, state_next;
    logic [7:0]         win_reg [FRAME_LEN];
    logic [7:0]         win_next [FRAME_LEN];
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [WIN_AW-1:0]  idx_reg, idx_next;
    logic [7:0]         acc_reg, acc_next;
    logic               meas_ok_reg, meas_ok_next;
    logic               echo_ok_reg, echo_ok_next;
    logic [CNT_W-1:0]   drop_reg, drop_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic [7:0]         len;
    logic               len_ok;
    logic [7:0]         rd_byte;
    logic               take_byte;
    logic               slot_free;
    logic               dec_emit;
    logic [CNT_W-1:0]   dec_drop;
    logic               head_ok;
    result_t            meas_res;
    result_t            echo_res;

    assign len       = win_reg[1];
    assign len_ok    = (len >= 8'd2) && (len <= 8'(FRAME_LEN));
    assign rd_byte   = win_reg[idx_reg];
    assign take_byte = rx_valid && ((held_reg != '0) || rx_item.is_header);
    assign slot_free = !res_valid_reg || res_pop;
    assign head_ok   = (held_reg == '0) || (win_reg[0] == HEADER_BYTE);

    assign res_valid = res_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        meas_res                 = '0;
        meas_res.result_kind     = KIND_MEAS;
        meas_res.algorithm_word  = {win_reg[3],  win_reg[2]};
        meas_res.raw_distance_a  = {win_reg[5],  win_reg[4]};
        meas_res.raw_distance_b  = {win_reg[7],  win_reg[6]};
        meas_res.raw_distance_c  = {win_reg[9],  win_reg[8]};
        meas_res.distance_a      = {win_reg[11], win_reg[10]};
        meas_res.distance_b      = {win_reg[13], win_reg[12]};
        meas_res.distance_c      = {win_reg[15], win_reg[14]};
        meas_res.apd_level       = win_reg[16];
        meas_res.supply_word     = {win_reg[18], win_reg[17]};
        meas_res.temperature_raw = {win_reg[20], win_reg[19]};

        // Payload bytes past the echo length read as zero.
        echo_res             = '0;
        echo_res.result_kind = KIND_ECHO;
        echo_res.echo_word   = {win_reg[2],
                                (len > 8'd3) ? win_reg[3] : 8'h00,
                                (len > 8'd4) ? win_reg[4] : 8'h00,
                                (len > 8'd5) ? win_reg[5] : 8'h00};

        if (meas_ok_reg)
        begin
            dec_emit = 1'b1;
            dec_drop = CNT_W'(FRAME_LEN);
        end
        else if (echo_ok_reg)
        begin
            dec_emit = known_id(win_reg[2]);
            dec_drop = len[CNT_W-1:0];
        end
        else
        begin
            dec_emit = 1'b0;
            dec_drop = CNT_W'(1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (take_byte && (held_reg == CNT_W'(FRAME_LEN - 1)))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == WIN_AW'(FRAME_LEN - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!dec_emit || slot_free)
                begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                if (drop_reg == CNT_W'(1))
                begin
                    state_next = ST_SYNC;
                end
            end
            ST_SYNC:
            begin
                if (head_ok)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        win_next       = win_reg;
        held_next      = held_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        meas_ok_next   = meas_ok_reg;
        echo_ok_next   = echo_ok_reg;
        drop_next      = drop_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        rx_pop         = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                rx_pop = rx_valid;
                if (take_byte)
                begin
                    win_next[held_reg[WIN_AW-1:0]] = rx_item.data;
                    held_next    = held_reg + 1'b1;
                    idx_next     = '0;
                    acc_next     = '0;
                    meas_ok_next = 1'b0;
                    echo_ok_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // acc holds the sum of the bytes before idx: compare, then add.
                if (idx_reg == WIN_AW'(FRAME_LEN - 1))
                begin
                    meas_ok_next = (acc_reg == rd_byte);
                end
                if (len_ok && ({{(8 - WIN_AW){1'b0}}, idx_reg} == len - 8'd1))
                begin
                    echo_ok_next = (acc_reg == rd_byte);
                end
                acc_next = acc_reg + rd_byte;
                idx_next = idx_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                drop_next = dec_drop;
                if (dec_emit && slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = meas_ok_reg ? meas_res : echo_res;
                end
            end
            ST_DROP:
            begin
                for (int i = 0; i < FRAME_LEN - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                held_next = held_reg - 1'b1;
                drop_next = drop_reg - 1'b1;
            end
            ST_SYNC:
            begin
                if (!head_ok)
                begin
                    for (int i = 0; i < FRAME_LEN - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    held_next = held_reg - 1'b1;
                end
            end
            default:
            begin
                rx_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            held_reg      <= '0;
            idx_reg       <= '0;
            drop_reg      <= '0;
            meas_ok_reg   <= 1'b0;
            echo_ok_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            meas_ok_reg   <= meas_ok_next;
            echo_ok_reg   <= echo_ok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(FRAME_LEN))
        else $error("window count beyond frame length");

    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (held_reg == CNT_W'(FRAME_LEN)))
        else $error("checksum scan on a window that is not full");

    a_head_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && held_reg != '0) |-> (win_reg[0] == HEADER_BYTE))
        else $error("window does not start with a header");

    a_drop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP) |-> (drop_reg != '0 && drop_reg <= held_reg))
        else $error("drop count out of range");

endmodule

// ===== hdl/rangefinder_frame_deframer.sv =====
// Top level of the rangefinder frame deframer: byte queue in front, frame engine behind.
//
// Received bytes are pushed one per request into a four-deep queue and then
// loaded into a 22-byte window at one byte per cycle while the queue holds
// bytes; bytes are dropped until the window starts with header 0x5A. Once the
// window is full the engine runs a single checksum pass through its one window
// read port, then decides (measurement frame, command echo, unknown echo or
// failure), then shifts the window by one byte per cycle: 22 bytes for a
// measurement, the echo length for an echo, one for a failure, followed by
// every byte ahead of the next header, and then checks for the header (or
// the empty window). The drop and the realignment together never shift out
// more than the 22 held bytes. The decision of a result that is to be emitted
// waits while a previous result is still unpopped.
// The queue keeps taking bytes while the engine is busy, and a finished result
// waits in its own register so that the window work goes on while it is held;
// only the decision of a further result waits for that register to be popped.
module rangefinder_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [15:0] algorithm_word,
    output logic [15:0] raw_distance_a,
    output logic [15:0] raw_distance_b,
    output logic [15:0] raw_distance_c,
    output logic [15:0] distance_a,
    output logic [15:0] distance_b,
    output logic [15:0] distance_c,
    output logic [7:0]  apd_level,
    output logic [15:0] supply_word,
    output logic [15:0] temperature_raw,
    output logic [31:0] echo_word
);
    import rfd_pkg::*;

    logic     item_valid;
    rx_item_t item;
    logic     item_pop;
    logic     res_valid;
    result_t  result;

    // Accept and tag each request; hold it until the engine takes it.
    rfd_byte_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Build the window, check it, emit the result and advance to the next header.
    rfd_frame_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (item_valid),
        .rx_item   (item),
        .rx_pop    (item_pop),
        .res_valid (res_valid),
        .res_pop   (pop),
        .result    (result)
    );

    assign empty           = !res_valid;
    assign result_kind     = result.result_kind;
    assign algorithm_word  = result.algorithm_word;
    assign raw_distance_a  = result.raw_distance_a;
    assign raw_distance_b  = result.raw_distance_b;
    assign raw_distance_c  = result.raw_distance_c;
    assign distance_a      = result.distance_a;
    assign distance_b      = result.distance_b;
    assign distance_c      = result.distance_c;
    assign apd_level       = result.apd_level;
    assign supply_word     = result.supply_word;
    assign temperature_raw = result.temperature_raw;
    assign echo_word       = result.echo_word;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the rangefinder frame deframer: byte stream in, decoded frames out.
module tb;

    import rfd_pkg::*;

    // Clocking and run bounds
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_AFTER   = 300;     // requests accepted before the long receiver hold
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 200;     // a few full windows at the engine's worst case
    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_FIELDS   = 12;

    // Command ids that the sensor echoes back with a result
    localparam logic [7:0] CMD_ID_LO_0      = 8'h01;
    localparam logic [7:0] CMD_ID_LO_1      = 8'h02;
    localparam logic [7:0] CMD_ID_MID_0     = 8'h10;
    localparam logic [7:0] CMD_ID_MID_1     = 8'h11;
    localparam logic [7:0] CMD_BAND_A_FIRST = 8'h40;
    localparam logic [7:0] CMD_BAND_A_LAST  = 8'h47;
    localparam logic [7:0] CMD_BAND_B_FIRST = 8'h4B;
    localparam logic [7:0] CMD_BAND_B_LAST  = 8'h4E;

    // One row of stimulus: the byte, and where it is obvious, the frame it must close
    typedef struct {
        logic [7:0] value;
        bit         typed;
        result_t    want;
    } byte_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic        result_kind;
    logic [15:0] algorithm_word;
    logic [15:0] raw_distance_a;
    logic [15:0] raw_distance_b;
    logic [15:0] raw_distance_c;
    logic [15:0] distance_a;
    logic [15:0] distance_b;
    logic [15:0] distance_c;
    logic [7:0]  apd_level;
    logic [15:0] supply_word;
    logic [15:0] temperature_raw;
    logic [31:0] echo_word;

    byte_row_t   byte_rows[$];
    result_t     pending_frames[$];
    logic [7:0]  mirror_window[FRAME_LEN];
    int unsigned mirror_count;
    int          fail_count;
    int          accepted_count;
    int          cycle_count = 0;
    bit          hold_results;
    int          send_calm;
    int          take_calm;

    rangefinder_frame_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .algorithm_word  (algorithm_word),
        .raw_distance_a  (raw_distance_a),
        .raw_distance_b  (raw_distance_b),
        .raw_distance_c  (raw_distance_c),
        .distance_a      (distance_a),
        .distance_b      (distance_b),
        .distance_c      (distance_c),
        .apd_level       (apd_level),
        .supply_word     (supply_word),
        .temperature_raw (temperature_raw),
        .echo_word       (echo_word)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: bound the run from the slowest correct case, several times over
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame predictor: a mirror of the window and its fill level
    // ------------------------------------------------------------------

    function automatic bit is_cmd_id(input logic [7:0] id);
        return id == CMD_ID_LO_0 || id == CMD_ID_LO_1 || id == CMD_ID_MID_0 ||
               id == CMD_ID_MID_1 ||
               (id >= CMD_BAND_A_FIRST && id <= CMD_BAND_A_LAST) ||
               (id >= CMD_BAND_B_FIRST && id <= CMD_BAND_B_LAST);
    endfunction

    // Mod-256 sum of the first n held bytes
    function automatic logic [7:0] window_sum(input int unsigned n);
        logic [7:0] acc;
        acc = 8'h00;
        for (int unsigned i = 0; i < n; i++)
            acc += mirror_window[i];
        return acc;
    endfunction

    function automatic logic [15:0] window_le16(input int unsigned lo);
        return {mirror_window[lo + 1], mirror_window[lo]};
    endfunction

    function automatic void shift_out(input int unsigned n);
        for (int unsigned i = 0; i + n < mirror_count; i++)
            mirror_window[i] = mirror_window[i + n];
        mirror_count -= n;
    endfunction

    // Consume n bytes, then realign so that the window opens on a header (or empties)
    function automatic void consume_and_resync(input int unsigned n);
        int unsigned first_header;
        shift_out(n);
        first_header = mirror_count;
        for (int unsigned i = 0; i < mirror_count; i++)
        begin
            if (mirror_window[i] == HEADER_BYTE)
            begin
                first_header = i;
                break;
            end
        end
        shift_out(first_header);
    endfunction

    // Take one byte; return 1 with the frame it completes, if any
    function automatic bit deframe_byte(input logic [7:0] b, output result_t frame);
        int unsigned len;
        logic [7:0]  id;
        bit          known;
        frame = '0;
        // An empty window waits for a header; anything else is dropped
        if (mirror_count == 0 && b != HEADER_BYTE)
            return 1'b0;
        mirror_window[mirror_count] = b;
        mirror_count++;
        if (mirror_count < FRAME_LEN)
            return 1'b0;

        // Measurement frame: the last byte sums everything before it
        if (window_sum(FRAME_LEN - 1) == mirror_window[FRAME_LEN - 1])
        begin
            frame.result_kind     = KIND_MEAS;
            frame.algorithm_word  = window_le16(2);
            frame.raw_distance_a  = window_le16(4);
            frame.raw_distance_b  = window_le16(6);
            frame.raw_distance_c  = window_le16(8);
            frame.distance_a      = window_le16(10);
            frame.distance_b      = window_le16(12);
            frame.distance_c      = window_le16(14);
            frame.apd_level       = mirror_window[16];
            frame.supply_word     = window_le16(17);
            frame.temperature_raw = window_le16(19);
            consume_and_resync(FRAME_LEN);
            return 1'b1;
        end

        // Command echo: length in byte 1, checksum at its last byte
        len = mirror_window[1];
        if (len >= 2 && len <= FRAME_LEN && window_sum(len - 1) == mirror_window[len - 1])
        begin
            id    = mirror_window[2];
            known = is_cmd_id(id);
            if (known)
            begin
                // payload bytes past the echo length read as zero
                frame.result_kind = KIND_ECHO;
                frame.echo_word   = {id,
                                     (len > 3) ? mirror_window[3] : 8'h00,
                                     (len > 4) ? mirror_window[4] : 8'h00,
                                     (len > 5) ? mirror_window[5] : 8'h00};
            end
            consume_and_resync(len);
            return known;
        end

        // Neither: drop the front byte and hunt for the next header
        consume_and_resync(1);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b);
        byte_rows.insert(byte_rows.size(), '{b, 1'b0, '0});
    endfunction

    function automatic logic [7:0] pick_cmd_id();
        int unsigned r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return CMD_ID_LO_0;
            1:       return CMD_ID_LO_1;
            2:       return CMD_ID_MID_0;
            3:       return CMD_ID_MID_1;
            default: return (r < 12) ? CMD_BAND_A_FIRST + 8'(r - 4)
                                     : CMD_BAND_B_FIRST + 8'(r - 12);
        endcase
    endfunction

    // Bytes that follow a frame; mostly free of headers so that the window clears
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == HEADER_BYTE && $urandom_range(0, 3) != 0)
            b = ~b;
        return b;
    endfunction

    // A full measurement frame; when damaged, one random bit of the body flips
    function automatic void add_measurement(input bit damaged);
        logic [7:0] f[FRAME_LEN];
        logic [7:0] acc;
        f[0] = HEADER_BYTE;
        acc  = HEADER_BYTE;
        for (int i = 1; i < FRAME_LEN - 1; i++)
        begin
            f[i] = 8'($urandom);
            acc += f[i];
        end
        f[FRAME_LEN - 1] = acc;
        if (damaged)
            f[$urandom_range(1, FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        for (int i = 0; i < FRAME_LEN; i++)
            add_byte(f[i]);
    endfunction

    // An echo of the given length padded out to a full window; checksum only in range
    function automatic void add_echo(input int unsigned len, input logic [7:0] id);
        logic [7:0] f[FRAME_LEN];
        logic [7:0] acc;
        f[0] = HEADER_BYTE;
        f[1] = 8'(len);
        f[2] = id;
        for (int i = 3; i < FRAME_LEN; i++)
            f[i] = filler_byte();
        if (len >= 3 && len <= FRAME_LEN)
        begin
            acc = 8'h00;
            for (int unsigned i = 0; i + 1 < len; i++)
                acc += f[i];
            f[len - 1] = acc;
        end
        for (int i = 0; i < FRAME_LEN; i++)
            add_byte(f[i]);
    endfunction

    function automatic int unsigned pick_echo_len();
        case ($urandom_range(0, 9))
            0:       return 3;
            1:       return FRAME_LEN;
            2, 3:    return $urandom_range(3, FRAME_LEN);
            default: return $urandom_range(3, 8);
        endcase
    endfunction

    function automatic int unsigned pick_bad_len();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            default: return $urandom_range(FRAME_LEN + 1, 255);
        endcase
    endfunction

    function automatic void build_stimulus();
        result_t all_ones;
        int      choice;
        // Directed: two stray bytes ahead of any header, then a measurement with
        // every payload byte at its maximum, whose checksum closes on 0x47
        all_ones             = '1;
        all_ones.result_kind = KIND_MEAS;
        all_ones.echo_word   = '0;
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(HEADER_BYTE);
        add_byte(8'h00);
        for (int i = 2; i < FRAME_LEN - 1; i++)
            add_byte(8'hFF);
        byte_rows.insert(byte_rows.size(), '{8'h47, 1'b1, all_ones});

        // Random: mostly well-formed frames with random content, some damage and noise
        while (byte_rows.size() < RANDOM_ITEMS + 24)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 30)
                add_measurement(1'b0);
            else if (choice < 50)
                add_echo(pick_echo_len(), pick_cmd_id());
            else if (choice < 58)
                add_echo(pick_echo_len(), 8'($urandom));
            else if (choice < 68)
                add_measurement(1'b1);
            else if (choice < 76)
                add_echo(pick_bad_len(), pick_cmd_id());
            else
                repeat ($urandom_range(1, 6))
                    add_byte(($urandom_range(0, 4) == 0) ? HEADER_BYTE : 8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Idle cycles before the next request; occasional stretches with none at all
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(20, 80);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] field_of(input result_t r, input int idx);
        case (idx)
            0:       return 32'(r.result_kind);
            1:       return 32'(r.algorithm_word);
            2:       return 32'(r.raw_distance_a);
            3:       return 32'(r.raw_distance_b);
            4:       return 32'(r.raw_distance_c);
            5:       return 32'(r.distance_a);
            6:       return 32'(r.distance_b);
            7:       return 32'(r.distance_c);
            8:       return 32'(r.apd_level);
            9:       return 32'(r.supply_word);
            10:      return 32'(r.temperature_raw);
            default: return r.echo_word;
        endcase
    endfunction

    function automatic string field_name(input int idx);
        case (idx)
            0:       return "result_kind";
            1:       return "algorithm_word";
            2:       return "raw_distance_a";
            3:       return "raw_distance_b";
            4:       return "raw_distance_c";
            5:       return "distance_a";
            6:       return "distance_b";
            7:       return "distance_c";
            8:       return "apd_level";
            9:       return "supply_word";
            10:      return "temperature_raw";
            default: return "echo_word";
        endcase
    endfunction

    // Hold the byte until the block takes it; lower push only across a real gap
    task automatic send_request(input logic [7:0] b);
        int gap;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic check_frame(input result_t got);
        result_t want;
        if (pending_frames.size() == 0)
        begin
            fail_count++;
            $display("%0t: frame popped with none expected: kind %0d echo_word %h",
                     $time, got.result_kind, got.echo_word);
        end
        else
        begin
            want = pending_frames.pop_front();
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (field_of(got, i) !== field_of(want, i))
                begin
                    fail_count++;
                    $display("%0t: %s expected %h actual %h", $time, field_name(i),
                             field_of(want, i), field_of(got, i));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: pop with random idling, and hold off entirely while asked
    // ------------------------------------------------------------------
    initial
    begin
        int      gap;
        result_t got;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(take_calm);
            @(negedge clk);
            if (gap > 0 || hold_results)
            begin
                pop <= 1'b0;
                while (gap > 0 || hold_results)
                begin
                    @(negedge clk);
                    if (gap > 0)
                        gap--;
                end
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            got.result_kind     = result_kind;
            got.algorithm_word  = algorithm_word;
            got.raw_distance_a  = raw_distance_a;
            got.raw_distance_b  = raw_distance_b;
            got.raw_distance_c  = raw_distance_c;
            got.distance_a      = distance_a;
            got.distance_b      = distance_b;
            got.distance_c      = distance_c;
            got.apd_level       = apd_level;
            got.supply_word     = supply_word;
            got.temperature_raw = temperature_raw;
            got.echo_word       = echo_word;
            check_frame(got);
        end
    end

    // Back-pressure: once traffic is flowing, stop popping for a long stretch so that
    // the result register, the window and the front queue all fill and full rises
    initial
    begin
        hold_results = 1'b0;
        wait (accepted_count >= HOLD_AFTER);
        @(posedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender and end of run
    // ------------------------------------------------------------------
    initial
    begin
        byte_row_t row;
        result_t   predicted;
        bit        has_frame;
        rst_n          = 1'b0;
        push           = 1'b0;
        rx_byte        = 8'h00;
        fail_count     = 0;
        accepted_count = 0;
        send_calm      = 0;
        take_calm      = 0;
        mirror_count   = 0;
        for (int i = 0; i < FRAME_LEN; i++)
            mirror_window[i] = 8'h00;
        build_stimulus();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; typed-in rows override the prediction, the rest use it
        foreach (byte_rows[i])
        begin
            row = byte_rows[i];
            send_request(row.value);
            accepted_count++;
            has_frame = deframe_byte(row.value, predicted);
            if (row.typed)
                pending_frames.insert(pending_frames.size(), row.want);
            else if (has_frame)
                pending_frames.insert(pending_frames.size(), predicted);
        end
        @(negedge clk);
        push <= 1'b0;

        // Wait for the last frames, then give a stray one time to show
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== rangefinder_frame_deframer.f =====
hdl/rfd_pkg.sv
hdl/rfd_byte_fifo.sv
hdl/rfd_frame_engine.sv
hdl/rangefinder_frame_deframer.sv
test/tb.sv
